### rtl/core/utf8_accent_folder_core_assert.svh
// ----------------------------------------------------------------------------
// utf8 accent folder assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef UTF8_ACCENT_FOLDER_CORE_ASSERT_SVH
`define UTF8_ACCENT_FOLDER_CORE_ASSERT_SVH

// same-cycle implication, reset masked
`define UAF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define UAF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/utf8af_pkg.sv
// ----------------------------------------------------------------------------
// utf8af_pkg
// types, constants and the folding table of the utf8 accent folder
// ----------------------------------------------------------------------------
package utf8af_pkg;

    localparam logic [7:0] ASCII_MASK  = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_CODE  = 8'hF0;

    localparam logic [20:0] FOLD_BASE  = 21'h0000C0;
    localparam logic [20:0] FOLD_TOP   = 21'h00017F;
    localparam int          FOLD_SIZE  = 192;
    localparam logic [7:0]  NO_FOLD    = 8'h2E;

    localparam logic [8*FOLD_SIZE-1:0] FOLD_TABLE = {
        "AAAAAA.CEEEEIIII",
        "DNOOOOO.OUUUUY..",
        "aaaaaa.ceeeeiiii",
        "dnooooo.ouuuuy.y",
        "AaAaAaCcCcCcCcDd",
        "DdEeEeEeEeEeGgGg",
        "GgGgHhHhIiIiIiIi",
        "Ii..JjKk.LlLlLlL",
        "lLlNnNnNn...OoOo",
        "Oo..RrRrRrSsSsSs",
        "SsTtTtTtUuUuUuUu",
        "UuUuWwYyYZzZzZz."
    };

    // one decoded group waiting to be sent out
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            text_last;
    } grp_t;

    function automatic logic [2:0] length_class(input logic [7:0] b);
        logic [2:0] len;
        if ((b & ASCII_MASK) == 8'h00) begin
            len = 3'd1;
        end
        else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            len = 3'd2;
        end
        else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            len = 3'd3;
        end
        else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            len = 3'd4;
        end
        else begin
            len = 3'd1;
        end
        return len;
    endfunction

    // zero when the entry is not mapped
    function automatic logic [7:0] fold_letter(input logic [7:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (int'(idx) < FOLD_SIZE) begin
            ch = FOLD_TABLE[8*(FOLD_SIZE-1-int'(idx)) +: 8];
        end
        if (ch == NO_FOLD) begin
            ch = 8'h00;
        end
        return ch;
    endfunction

endpackage

### rtl/core/utf8af_front.sv
// ----------------------------------------------------------------------------
// utf8af_front
// takes bytes, groups them into code points and folds mapped letters
// ----------------------------------------------------------------------------
module utf8af_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        in_byte,
    input  logic              text_last,
    input  logic              q_full,
    output logic              q_push,
    output utf8af_pkg::grp_t  q_wdata
);
    import utf8af_pkg::*;

    logic [2:0][7:0] held_bytes_reg, held_bytes_next;
    logic [1:0]      held_count_reg, held_count_next;
    logic [2:0]      seq_len_reg, seq_len_next;

    logic [3:0][7:0] seq_bytes;
    logic [2:0]      cnt;
    logic [2:0]      len;
    logic            complete;
    logic            emit;
    logic            accept;
    logic [20:0]     cp;
    logic [7:0]      cp_off;
    logic [7:0]      letter;
    logic            folded;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign cnt      = {1'b0, held_count_reg} + 3'd1;

    always_comb
    begin
        seq_bytes[0] = (held_count_reg == 2'd0) ? in_byte : held_bytes_reg[0];
        seq_bytes[1] = (held_count_reg == 2'd1) ? in_byte :
                       (held_count_reg >  2'd1) ? held_bytes_reg[1] : 8'h00;
        seq_bytes[2] = (held_count_reg == 2'd2) ? in_byte :
                       (held_count_reg >  2'd2) ? held_bytes_reg[2] : 8'h00;
        seq_bytes[3] = (held_count_reg == 2'd3) ? in_byte : 8'h00;
    end

    always_comb
    begin
        if (held_count_reg == 2'd0) begin
            len = length_class(in_byte);
        end
        else if (seq_len_reg < 3'd1 || seq_len_reg > 3'd4) begin
            len = cnt;
        end
        else begin
            len = seq_len_reg;
        end
    end

    assign complete = cnt >= len;
    assign emit     = complete || text_last;

    always_comb
    begin
        unique case (len)
            3'd2:    cp = {10'd0, seq_bytes[0][4:0], seq_bytes[1][5:0]};
            3'd3:    cp = {5'd0, seq_bytes[0][3:0], seq_bytes[1][5:0],
                           seq_bytes[2][5:0]};
            3'd4:    cp = {seq_bytes[0][2:0], seq_bytes[1][5:0],
                           seq_bytes[2][5:0], seq_bytes[3][5:0]};
            default: cp = {13'd0, seq_bytes[0]};
        endcase
    end

    assign cp_off = cp[7:0] - FOLD_BASE[7:0];
    assign letter = fold_letter(cp_off);
    assign folded = complete && (cp >= FOLD_BASE) && (cp <= FOLD_TOP) && (letter != 8'h00);

    always_comb
    begin
        q_push            = accept && emit;
        q_wdata.text_last = text_last;
        if (folded) begin
            q_wdata.bytes    = {24'd0, letter};
            q_wdata.last_idx = 2'd0;
        end
        else begin
            q_wdata.bytes    = seq_bytes;
            q_wdata.last_idx = held_count_reg;
        end
    end

    always_comb
    begin
        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        seq_len_next    = seq_len_reg;
        if (accept) begin
            if (emit) begin
                held_bytes_next = '0;
                held_count_next = 2'd0;
                seq_len_next    = 3'd0;
            end
            else begin
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) == held_count_reg) begin
                        held_bytes_next[i] = in_byte;
                    end
                end
                held_count_next = cnt[1:0];
                seq_len_next    = len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_bytes_reg <= '0;
            held_count_reg <= 2'd0;
            seq_len_reg    <= 3'd0;
        end
        else begin
            held_bytes_reg <= held_bytes_next;
            held_count_reg <= held_count_next;
            seq_len_reg    <= seq_len_next;
        end
    end

endmodule

### rtl/core/utf8af_queue.sv
// ----------------------------------------------------------------------------
// utf8af_queue
// small first-in first-out buffer of decoded groups
// ----------------------------------------------------------------------------
module utf8af_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  utf8af_pkg::grp_t  wdata,
    output logic              full,
    input  logic              pop,
    output utf8af_pkg::grp_t  rdata,
    output logic              not_empty
);
    import utf8af_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    grp_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rdata     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/utf8af_back.sv
// ----------------------------------------------------------------------------
// utf8af_back
// sends each queued group out one byte per transfer
// ----------------------------------------------------------------------------
module utf8af_back (
    input  logic              clk,
    input  logic              rst_n,
    input  utf8af_pkg::grp_t  head,
    input  logic              head_valid,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic              run_last,
    output logic              text_end
);
    import utf8af_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       run_last_reg, run_last_next;
    logic       text_end_reg, text_end_next;
    logic [1:0] pos_reg, pos_next;
    logic       load;
    logic       take;
    logic       at_end;

    assign load   = !out_valid_reg || !out_stall;
    assign take   = head_valid && load;
    assign at_end = pos_reg == head.last_idx;
    assign pop    = take && at_end;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        run_last_next  = run_last_reg;
        text_end_next  = text_end_reg;
        pos_next       = pos_reg;
        if (load) begin
            out_valid_next = head_valid;
        end
        if (take) begin
            out_byte_next = head.bytes[pos_reg];
            run_last_next = at_end;
            text_end_next = at_end && head.text_last;
            pos_next      = at_end ? 2'd0 : pos_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            pos_reg       <= 2'd0;
        end
        else begin
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        run_last_reg <= run_last_next;
        text_end_reg <= text_end_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign text_end  = text_end_reg;

endmodule

### rtl/core/utf8_accent_folder_core.sv
// path: a finished group is queued, then its first byte is registered at the output
// throughput: one input byte per cycle, one output byte per cycle, when not stalled
// up to four bytes a group, drained a byte a cycle unless stalled; queue absorbs bursts
// reset: asynchronous, clears held sequence, queue pointers and output valid
// ----------------------------------------------------------------------------
// utf8_accent_folder_core
// utf8 stream folder: accented latin letters become plain ascii letters
// ----------------------------------------------------------------------------
module utf8_accent_folder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       text_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       text_end
);
    import utf8af_pkg::*;

    grp_t q_wdata;
    grp_t q_rdata;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_not_empty;

    utf8af_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .text_last (text_last),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    utf8af_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_not_empty)
    );

    utf8af_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_rdata),
        .head_valid (q_not_empty),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .text_end   (text_end)
    );

endmodule

### rtl/core/utf8af_checker.sv
// ----------------------------------------------------------------------------
// utf8af_checker
// port-level checks on the utf8 accent folder
// ----------------------------------------------------------------------------
`include "utf8_accent_folder_core_assert.svh"

module utf8af_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       text_end
);

    // stalled output transfer keeps its payload
    `UAF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(run_last) && $stable(text_end), "output changed while stalled")

    // end of text is always the end of a run
    `UAF_ASSERT_NOW(a_end_is_run_last, clk, rst_n, out_valid && text_end, run_last, "text_end without run_last")

    // nothing comes out and the input is not stalled in the first cycle after reset
    `UAF_ASSERT_NOW(a_quiet_after_reset, clk, rst_n, $rose(rst_n), !out_valid && !in_stall, "activity right after reset")

    // output register still empty the cycle after reset was seen
    `UAF_ASSERT_NOW(a_no_pass_through, clk, rst_n, $past(!rst_n), !out_valid, "output valid right after reset")

endmodule

bind utf8_accent_folder_core utf8af_checker u_checker (.*);
